// ----- hdl/rhsv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types, constants and the restoring divide step for the RGB to HSV
// converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

    // Divider geometry: 16-bit dividend, 9-bit divisor, 7-bit quotient,
    // two quotient bits per stage over four stages, only bit 0 in the last.
    localparam int NUM_W     = 16;
    localparam int DEN_W     = 9;
    localparam int QUO_W     = 7;
    localparam int DIV_STG   = 4;
    localparam int SHIFT_W   = 3;

    // Hue sector offsets and the full circle, in degrees.
    localparam logic [8:0] HUE_GREEN_OFS = 9'd120;
    localparam logic [8:0] HUE_BLUE_OFS  = 9'd240;
    localparam logic [8:0] HUE_FULL      = 9'd360;

    // Scale factors for the percent terms.
    localparam logic [15:0] PCT_X2       = 16'd200;
    localparam logic [15:0] VAL_BIAS     = 16'd255;
    // floor(n / 510) == (n * VAL_RECIP) >> 24 for every n below 66052.
    localparam logic [15:0] VAL_RECIP    = 16'd32897;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Per-pixel flags that ride alongside the dividers.
    typedef struct packed {
        sector_t sector;
        logic    neg;
        logic    grey;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic             q;
    } div_step_t;

    // One restoring step: subtract the shifted divisor when it fits.
    function automatic div_step_t div_step(input logic [NUM_W-1:0]   rem,
                                           input logic [DEN_W-1:0]   den,
                                           input logic [SHIFT_W-1:0] sh);
        logic [NUM_W-1:0] trial;
        div_step_t        res;
        trial = NUM_W'(den) << sh;
        if (rem >= trial)
        begin
            res.rem = rem - trial;
            res.q   = 1'b1;
        end
        else
        begin
            res.rem = rem;
            res.q   = 1'b0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rhsv_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_div
// Four-stage restoring divider, two quotient bits per stage (the last stage
// gives only bit 0), quotient below 128. Gives the quotient and whether a remainder is left.
// ----------------------------------------------------------------------------
module rhsv_div (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [rhsv_pkg::NUM_W-1:0]   num,
    input  wire logic [rhsv_pkg::DEN_W-1:0]   den,
    output logic      [rhsv_pkg::QUO_W-1:0]   quo,
    output logic                              rem_nz
);

    localparam int NS = rhsv_pkg::DIV_STG;

    logic [rhsv_pkg::NUM_W-1:0] rem_reg  [NS];
    logic [rhsv_pkg::NUM_W-1:0] rem_next [NS];
    logic [rhsv_pkg::QUO_W-1:0] quo_reg  [NS];
    logic [rhsv_pkg::QUO_W-1:0] quo_next [NS];
    logic [rhsv_pkg::DEN_W-1:0] den_reg  [NS-1];

    logic [rhsv_pkg::NUM_W-1:0] rem_in [NS];
    logic [rhsv_pkg::QUO_W-1:0] quo_in [NS];
    logic [rhsv_pkg::DEN_W-1:0] den_in [NS];

    always_comb
    begin
        rem_in[0] = num;
        quo_in[0] = '0;
        den_in[0] = den;
        for (int s = 1; s < NS; s++)
        begin
            rem_in[s] = rem_reg[2'(s - 1)];
            quo_in[s] = quo_reg[2'(s - 1)];
            den_in[s] = den_reg[2'(s - 1)];
        end
    end

    always_comb
    begin
        rhsv_pkg::div_step_t st_a;
        rhsv_pkg::div_step_t st_b;
        st_b = '0;
        for (int s = 0; s < NS; s++)
        begin
            // high bit of the pair
            st_a = rhsv_pkg::div_step(rem_in[s], den_in[s],
                                      rhsv_pkg::SHIFT_W'(6 - 2 * s));
            quo_next[s] = quo_in[s] | (rhsv_pkg::QUO_W'(st_a.q) << (6 - 2 * s));
            rem_next[s] = st_a.rem;
            // low bit of the pair; the last stage has only bit 0
            if (s < NS - 1)
            begin
                st_b = rhsv_pkg::div_step(st_a.rem, den_in[s],
                                          rhsv_pkg::SHIFT_W'(5 - 2 * s));
                quo_next[s] = quo_next[s]
                            | (rhsv_pkg::QUO_W'(st_b.q) << (5 - 2 * s));
                rem_next[s] = st_b.rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
            for (int s = 0; s < NS - 1; s++)
            begin
                den_reg[s] <= den_in[s];
            end
        end
    end

    assign quo    = quo_reg[NS-1];
    assign rem_nz = (rem_reg[NS-1] != '0);

endmodule
`default_nettype wire

// ----- hdl/rgb_to_hsv_convert.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// Converts one 8-bit RGB pixel per cycle, unless a result is held at the
// output, to whole-degree hue and rounded percent saturation and value.
// ----------------------------------------------------------------------------
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------
//  in      | in_valid / in_stall         | red, green, blue (8 b each)
//  out     | out_valid / out_stall       | hue (9 b), saturation, brightness
//
//  Throughput is one pixel per clock unless a result is held at the output.
//  The two 4-stage restoring dividers (hue fraction and saturation) set the
//  depth of the pipe.
//  Reset clears only the valid bits; payload registers start undefined.
//  A stalled result freezes the whole pipe; in_stall rises only while a
//  result waits at the output, so bubbles in the pipe never hold the input.
//
//  Stages: 1 max/min/sector, 2 numerators, 3..6 divide (value reciprocal
//  multiply rides along in 3 and 4), 7 hue fix-up and output registers.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [8:0]      hue,
    output logic [6:0]      saturation,
    output logic [6:0]      brightness
);

    localparam int NV = 7;  // pipeline depth
    localparam int ND = rhsv_pkg::DIV_STG;

    logic advance;
    logic [NV-1:0] vld_reg;
    logic [NV-1:0] vld_next;

    // Advance the whole pipe unless a finished request is held at the output.
    assign advance  = !(vld_reg[NV-1] && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        vld_next = {vld_reg[NV-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: max, min, spread, sector and the signed channel difference
    // ------------------------------------------------------------------
    logic [7:0]        mx_c, mn_c, pa_c, pb_c;
    rhsv_pkg::sector_t sec_c;

    always_comb
    begin
        mx_c = (red >= green) ? red : green;
        mx_c = (blue > mx_c) ? blue : mx_c;
        mn_c = (red <= green) ? red : green;
        mn_c = (blue < mn_c) ? blue : mn_c;
        // red wins ties, then green, then blue
        if (red >= green && red >= blue)
        begin
            sec_c = rhsv_pkg::SEC_RED;
            pa_c  = green;
            pb_c  = blue;
        end
        else if (green >= blue)
        begin
            sec_c = rhsv_pkg::SEC_GREEN;
            pa_c  = blue;
            pb_c  = red;
        end
        else
        begin
            sec_c = rhsv_pkg::SEC_BLUE;
            pa_c  = red;
            pb_c  = green;
        end
    end

    logic [7:0]        mx1_reg, d1_reg, adiff1_reg;
    logic              neg1_reg;
    rhsv_pkg::sector_t sec1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mx1_reg    <= mx_c;
            d1_reg     <= mx_c - mn_c;
            adiff1_reg <= (pa_c >= pb_c) ? (pa_c - pb_c) : (pb_c - pa_c);
            neg1_reg   <= (pa_c < pb_c);
            sec1_reg   <= sec_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerators and divisors
    // ------------------------------------------------------------------
    logic [15:0]     num_h2_reg, num_s2_reg, num_v2_reg;
    logic [8:0]      den_h2_reg, den_s2_reg;
    rhsv_pkg::side_t side2_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_h2_reg       <= 16'(adiff1_reg) * 16'd60;
            den_h2_reg       <= {1'b0, d1_reg};
            // round(100*d/max) = floor((200*d + max) / (2*max))
            num_s2_reg       <= 16'(d1_reg) * rhsv_pkg::PCT_X2 + 16'(mx1_reg);
            den_s2_reg       <= {mx1_reg, 1'b0};
            // round(100*max/255) = floor((200*max + 255) / 510)
            num_v2_reg       <= 16'(mx1_reg) * rhsv_pkg::PCT_X2 + rhsv_pkg::VAL_BIAS;
            side2_reg.sector <= sec1_reg;
            side2_reg.neg    <= neg1_reg;
            side2_reg.grey   <= (d1_reg == 8'd0);
        end
    end

    // ------------------------------------------------------------------
    // Stages 3..6: dividers, with flags and value carried alongside
    // ------------------------------------------------------------------
    logic [6:0] quo_h, quo_s;
    logic       nz_h;
    logic       nz_s;

    rhsv_div u_div_hue (
        .clk    (clk),
        .en     (advance),
        .num    (num_h2_reg),
        .den    (den_h2_reg),
        .quo    (quo_h),
        .rem_nz (nz_h)
    );

    rhsv_div u_div_sat (
        .clk    (clk),
        .en     (advance),
        .num    (num_s2_reg),
        .den    (den_s2_reg),
        .quo    (quo_s),
        .rem_nz (nz_s)
    );

    rhsv_pkg::side_t side_reg [ND];
    logic [31:0]     vprod3_reg;
    logic [6:0]      val_reg [ND-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= side2_reg;
            for (int s = 1; s < ND; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            // value: multiply by the reciprocal of 510, then keep bits 30..24
            vprod3_reg <= 32'(num_v2_reg) * 32'(rhsv_pkg::VAL_RECIP);
            val_reg[0] <= vprod3_reg[30:24];
            for (int s = 1; s < ND - 1; s++)
            begin
                val_reg[s] <= val_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: hue fix-up per sector, output registers
    // ------------------------------------------------------------------
    rhsv_pkg::side_t sd;
    logic [8:0]      q9;
    logic [8:0]      hue_next;
    logic [6:0]      sat_next;

    always_comb
    begin
        sd = side_reg[ND-1];
        q9 = {2'b00, quo_h};
        case (sd.sector)
            rhsv_pkg::SEC_GREEN:
                // floor of a negative fraction steps down when a remainder is left
                hue_next = sd.neg ? (rhsv_pkg::HUE_GREEN_OFS - q9 - 9'(nz_h))
                                  : (rhsv_pkg::HUE_GREEN_OFS + q9);
            rhsv_pkg::SEC_BLUE:
                hue_next = sd.neg ? (rhsv_pkg::HUE_BLUE_OFS - q9 - 9'(nz_h))
                                  : (rhsv_pkg::HUE_BLUE_OFS + q9);
            default:
                // red: truncate toward zero, then wrap a negative angle
                hue_next = (sd.neg && q9 != 9'd0) ? (rhsv_pkg::HUE_FULL - q9) : q9;
        endcase
        sat_next = quo_s;
        if (sd.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    logic [8:0] hue_reg;
    logic [6:0] saturation_reg;
    logic [6:0] brightness_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg        <= hue_next;
            saturation_reg <= sat_next;
            brightness_reg <= val_reg[ND-2];
        end
    end

    assign out_valid  = vld_reg[NV-1];
    assign hue        = hue_reg;
    assign saturation = saturation_reg;
    assign brightness = brightness_reg;

endmodule
`default_nettype wire

// ----- hdl/rhsv_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhsv_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [8:0] hue,
    input wire logic [6:0] saturation,
    input wire logic [6:0] brightness
);

    // A held output request must back-pressure the input.
    a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input not stalled while output request is held");

    // Without a held output request the input is never stalled.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
        else $error("input stalled with no held output request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(hue) && $stable(saturation) && $stable(brightness)))
        else $error("held output request changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hue <= 9'd359 && saturation <= 7'd100 && brightness <= 7'd100))
        else $error("result out of range");

    // A stalled input request stays up until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> in_valid)
        else $error("stalled input request dropped");

endmodule

bind rgb_to_hsv_convert rhsv_checker u_rhsv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
);
`default_nettype wire
